// File: src/wkd_pkg.sv
// ----------------------------------------------------------------------------
// wkd_pkg: shared definitions for the key number decoder
// Field widths, character codes, status codes and the controller state type.
// ----------------------------------------------------------------------------
package wkd_pkg;

    // Payload widths of the character and result beats.
    localparam int KEY_CHAR_W  = 8;
    localparam int KEY_VALUE_W = 32;
    localparam int STATUS_W    = 2;

    // Default limit on the number of characters looked at in one key.
    localparam int MAX_KEY_CHARS_DEF = 256;

    // Character codes of interest.
    localparam logic [KEY_CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [KEY_CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [KEY_CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Multiplier applied to the running value per decimal digit.
    localparam int DECIMAL_BASE = 10;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACES = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // Controller states: collect characters, divide, hand over the result.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// File: src/wkd_in_if.sv
// ----------------------------------------------------------------------------
// wkd_in_if: character channel
// One beat carries one key character and the flag on the final character.
// ----------------------------------------------------------------------------
interface wkd_in_if;
    import wkd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KEY_CHAR_W-1:0] key_char;
    logic                  last_char;

    modport source (output valid, output key_char, output last_char, input ready);
    modport sink   (input valid, input key_char, input last_char, output ready);

endinterface

// File: src/wkd_out_if.sv
// ----------------------------------------------------------------------------
// wkd_out_if: result channel
// One beat carries the decoded key number and its status.
// ----------------------------------------------------------------------------
interface wkd_out_if;
    import wkd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KEY_VALUE_W-1:0] key_value;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output key_value, output status, input ready);
    modport sink   (input valid, input key_value, input status, output ready);

endinterface

// File: src/websocket_key_number_decode_unit.sv
// ----------------------------------------------------------------------------
// websocket_key_number_decode_unit: handshake key number decoder
// Folds the decimal digits of a key header into a number, counts its spaces
// and divides the number by the space count with a bit-serial divider.
// ----------------------------------------------------------------------------
// Characters are taken at one beat per cycle while the block is idle. After the
// beat that carries the final-character flag, the block runs its restoring
// divider, which retires one quotient bit per cycle, then loads the result
// register, and only then takes the next key's first character. The result
// register holds a finished beat while the block collects the next key;
// only a key that ends while the previous result has not been taken waits
// for it. Only the first MAX_KEY_CHARS characters of a key count; later
// ones are taken and dropped.
// ----------------------------------------------------------------------------
module websocket_key_number_decode_unit #(
    parameter int MAX_KEY_CHARS = wkd_pkg::MAX_KEY_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wkd_in_if.sink     i_in,
    wkd_out_if.source  o_out
);
    import wkd_pkg::*;

    localparam int CNT_W     = $clog2(MAX_KEY_CHARS + 1);
    localparam int SUM_W     = KEY_VALUE_W + 4;
    localparam int STEP_W    = $clog2(KEY_VALUE_W);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_KEY_CHARS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(KEY_VALUE_W - 1);

    // Controller and key state.
    t_state                 r_state, n_state;
    logic [KEY_VALUE_W-1:0] r_digit, n_digit;
    logic [CNT_W-1:0]       r_spaces, n_spaces;
    logic [CNT_W-1:0]       r_chars, n_chars;
    logic                   r_ovf, n_ovf;

    // Divider datapath.
    logic [KEY_VALUE_W-1:0] r_quot;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_divisor;
    logic [STEP_W-1:0]      r_step;
    logic [STATUS_W-1:0]    r_div_status;

    // Result register.
    logic                   r_out_valid;
    logic [KEY_VALUE_W-1:0] r_out_value;
    logic [STATUS_W-1:0]    r_out_status;

    // Controller outputs.
    logic w_in_ready;
    logic w_div_run;
    logic w_out_load;

    logic w_in_acc;
    logic w_key_end;
    logic w_take;
    logic w_is_digit;
    logic w_is_space;
    logic [SUM_W-1:0]       w_sum;
    logic [CNT_W:0]         w_trial;
    logic                   w_fits;

    assign w_in_acc  = i_in.valid && w_in_ready;
    assign w_key_end = w_in_acc && i_in.last_char;
    assign w_take    = w_in_acc && (r_chars < CNT_MAX);

    // Character classification.
    assign w_is_digit = (i_in.key_char inside {[CHAR_ZERO:CHAR_NINE]});
    assign w_is_space = (i_in.key_char == CHAR_SPACE);

    // Decimal fold: value * 8 + value * 2 + digit.
    assign w_sum = ({4'b0, r_digit} << 3) + ({4'b0, r_digit} << 1)
                 + SUM_W'(i_in.key_char[3:0]);

    // Key state after the current beat.
    always_comb begin
        n_digit  = r_digit;
        n_spaces = r_spaces;
        n_chars  = r_chars;
        n_ovf    = r_ovf;
        if (w_take) begin
            n_chars = r_chars + 1'b1;
            if (w_is_digit) begin
                if (r_ovf || (|w_sum[SUM_W-1:KEY_VALUE_W])) begin
                    n_digit = '1;
                    n_ovf   = 1'b1;
                end else begin
                    n_digit = w_sum[KEY_VALUE_W-1:0];
                end
            end else if (w_is_space) begin
                n_spaces = r_spaces + 1'b1;
            end
        end
    end

    // Key state registers, cleared when the key ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_key_end) begin
            r_digit  <= '0;
            r_spaces <= '0;
            r_chars  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_digit  <= n_digit;
            r_spaces <= n_spaces;
            r_chars  <= n_chars;
            r_ovf    <= n_ovf;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_key_end) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_div_run  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_DIV:  w_div_run  = 1'b1;
            ST_DONE: w_out_load = !r_out_valid || o_out.ready;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring division step: shift in the next dividend bit and subtract.
    assign w_trial = {r_rem, r_quot[KEY_VALUE_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (w_key_end) begin
            r_quot    <= n_digit;
            r_rem     <= '0;
            r_divisor <= n_spaces;
            r_step    <= '0;
            if (n_spaces == '0) begin
                r_div_status <= STATUS_NO_SPACES;
            end else if (n_ovf) begin
                r_div_status <= STATUS_OVERFLOW;
            end else begin
                r_div_status <= STATUS_OK;
            end
        end else if (w_div_run) begin
            r_quot <= {r_quot[KEY_VALUE_W-2:0], w_fits};
            r_rem  <= w_fits ? CNT_W'(w_trial - {1'b0, r_divisor}) : w_trial[CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_div_status;
            r_out_value  <= (r_div_status == STATUS_NO_SPACES) ? '0 : r_quot;
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.key_value = r_out_value;
    assign o_out.status    = r_out_status;

    // A new result beat appears only from the hand-over state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result beat raised outside the hand-over state");

    // While the divider owns the key, no new characters have been counted.
    a_key_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_chars == '0 && r_spaces == '0))
        else $error("key state not clear while dividing");

    // The character count never passes the limit.
    a_char_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars <= CNT_MAX)
        else $error("character count above limit");

    // A saturated value stays at all ones.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_digit == '1))
        else $error("overflow flag without saturated value");

    // The partial remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_divisor != '0) |-> (r_rem < r_divisor))
        else $error("divider remainder out of range");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: key number decoder check
// Streams key header characters into the decoder and compares every result
// beat with a predictor kept alongside the stream. A short table of keys
// comes first: an empty digit string, no spaces, the largest value that fits,
// saturation, no spaces winning over saturation, and bytes next to the digit
// range. Random keys follow. Most are well-formed mixes of digits, spaces and
// filler, with some long digit runs, digit-only keys, byte noise and keys
// near or past the length limit. Both sides pause at random between beats.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wkd_pkg::*;

    localparam int KEY_LIMIT    = MAX_KEY_CHARS_DEF;
    localparam int RANDOM_CHARS = 700;
    localparam int MAX_WAIT     = 10;
    localparam int DRAIN_CYCLES = 60;

    typedef logic [KEY_CHAR_W-1:0] t_char_q[$];

    typedef struct packed {
        logic [KEY_VALUE_W-1:0] value;
        logic [STATUS_W-1:0]    status;
    } t_key_number;

    typedef struct {
        string                  text;
        bit                     typed;
        logic [KEY_VALUE_W-1:0] value;
        logic [STATUS_W-1:0]    status;
    } t_key_case;

    typedef enum {
        KEY_WELL_FORMED,
        KEY_BIG,
        KEY_DIGITS_ONLY,
        KEY_NOISE,
        KEY_OVERLONG
    } t_key_kind;

    logic i_clk;
    logic i_rst_n;

    wkd_in_if  key_chars ();
    wkd_out_if key_numbers ();

    websocket_key_number_decode_unit #(
        .MAX_KEY_CHARS(KEY_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (key_chars),
        .o_out  (key_numbers)
    );

    // Directed keys; rows with typed set carry their result, the rest use
    // the predictor.
    t_key_case directed_keys[6] = '{
        '{" ",           1'b1, 32'd0,        STATUS_OK},
        '{"\377",        1'b1, 32'd0,        STATUS_NO_SPACES},
        '{"4294967295 ", 1'b1, 32'hFFFFFFFF, STATUS_OK},
        '{"4294967296 ", 1'b1, 32'hFFFFFFFF, STATUS_OVERFLOW},
        '{"9999999999",  1'b1, 32'd0,        STATUS_NO_SPACES},
        '{" 0/9:8 ",     1'b0, 32'd0,        STATUS_OK}
    };

    t_key_number pending_numbers[$];
    int unsigned mismatches      = 0;
    int unsigned numbers_checked = 0;
    int unsigned chars_counted   = 0;
    int unsigned keys_sent       = 0;
    int unsigned status_seen[4]  = '{0, 0, 0, 0};

    // Predictor state for the key being collected.
    logic [KEY_VALUE_W-1:0] acc_value     = '0;
    int unsigned            acc_spaces    = 0;
    int unsigned            acc_chars     = 0;
    bit                     acc_saturated = 1'b0;

    bit          chars_steady  = 1'b0;
    bit          numbers_steady = 1'b0;
    int unsigned numbers_stall = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #400us;
        $display("FAIL websocket_key_number_decode_unit");
        $finish;
    end

    // Folds one accepted character into the predicted key state and returns
    // 1 with the expected number when the character ends the key.
    function automatic bit decode_char(input logic [KEY_CHAR_W-1:0] c, input bit is_final,
                                       output t_key_number number);
        logic [2*KEY_VALUE_W-1:0] widened;
        number = '0;
        if (acc_chars < KEY_LIMIT) begin
            acc_chars++;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                widened = (2*KEY_VALUE_W)'(acc_value) * DECIMAL_BASE
                          + (2*KEY_VALUE_W)'(c - CHAR_ZERO);
                if (acc_saturated || widened > 64'hFFFF_FFFF) begin
                    acc_value     = '1;
                    acc_saturated = 1'b1;
                end else begin
                    acc_value = widened[KEY_VALUE_W-1:0];
                end
            end else if (c == CHAR_SPACE) begin
                acc_spaces++;
            end
        end
        if (!is_final)
            return 1'b0;
        // No spaces wins over saturation.
        if (acc_spaces == 0) begin
            number.value  = '0;
            number.status = STATUS_NO_SPACES;
        end else begin
            number.value  = acc_value / acc_spaces;
            number.status = acc_saturated ? STATUS_OVERFLOW : STATUS_OK;
        end
        acc_value     = '0;
        acc_spaces    = 0;
        acc_chars     = 0;
        acc_saturated = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [KEY_CHAR_W-1:0] random_digit();
        return CHAR_ZERO + KEY_CHAR_W'($urandom_range(0, 9));
    endfunction

    // Mostly digits, some spaces, the rest any byte.
    function automatic logic [KEY_CHAR_W-1:0] mixed_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return random_digit();
        if (pick < 7)
            return CHAR_SPACE;
        return KEY_CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic t_char_q random_key(input t_key_kind kind);
        t_char_q     text;
        int unsigned len;
        case (kind)
            KEY_BIG: begin
                len = $urandom_range(10, 12);
                repeat (len) text.push_back(random_digit());
                repeat ($urandom_range(1, 4))
                    text.insert($urandom_range(0, text.size()), CHAR_SPACE);
            end
            KEY_DIGITS_ONLY: begin
                repeat ($urandom_range(1, 12)) text.push_back(random_digit());
            end
            KEY_NOISE: begin
                repeat ($urandom_range(1, 8)) text.push_back(KEY_CHAR_W'($urandom_range(0, 255)));
            end
            default: begin
                len = (kind == KEY_OVERLONG) ? $urandom_range(KEY_LIMIT - 6, KEY_LIMIT + 40)
                                             : $urandom_range(1, 24);
                repeat (len) text.push_back(mixed_char());
            end
        endcase
        return text;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Drives one character beat, after a random gap, and returns at the edge
    // where it is taken.
    task automatic send_char(input logic [KEY_CHAR_W-1:0] c, input bit is_final);
        int unsigned gap;
        gap = chars_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            key_chars.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_chars.valid     <= 1'b1;
        key_chars.key_char  <= c;
        key_chars.last_char <= is_final;
        @(posedge i_clk);
        while (!key_chars.ready) @(posedge i_clk);
    endtask

    // Sends a whole key; the typed result, if given, replaces the predicted one.
    task automatic send_key(input t_char_q text, input bit typed, input t_key_number typed_number);
        t_key_number number;
        foreach (text[i]) begin
            send_char(text[i], i == text.size() - 1);
            if (i < KEY_LIMIT)
                chars_counted++;
            if (decode_char(text[i], i == text.size() - 1, number))
                pending_numbers.push_back(typed ? typed_number : number);
        end
        keys_sent++;
    endtask

    task automatic check_number(input t_key_number seen);
        t_key_number want;
        if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("unexpected beat value %h status %0d",
                                      seen.value, seen.status));
            return;
        end
        want = pending_numbers.pop_front();
        numbers_checked++;
        status_seen[want.status]++;
        if (seen.value !== want.value)
            report_mismatch($sformatf("key_value %h, expected %h", seen.value, want.value));
        if (seen.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, want.status));
    endtask

    // Result side: check each beat, then stall ready for a random count.
    always @(posedge i_clk) begin
        if (key_numbers.valid && key_numbers.ready) begin
            check_number('{value: key_numbers.key_value, status: key_numbers.status});
            if ($urandom_range(0, 7) == 0)
                numbers_steady = !numbers_steady;
            numbers_stall = numbers_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (numbers_stall > 0) begin
            key_numbers.ready <= 1'b0;
            numbers_stall--;
        end else begin
            key_numbers.ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_char_q     text;
        t_key_number typed_number;
        t_key_kind   kind;
        int unsigned pick;
        int unsigned random_start;

        i_rst_n             <= 1'b0;
        key_chars.valid     <= 1'b0;
        key_chars.key_char  <= '0;
        key_chars.last_char <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (directed_keys[n]) begin
            text.delete();
            for (int i = 0; i < directed_keys[n].text.len(); i++)
                text.push_back(directed_keys[n].text[i]);
            typed_number.value  = directed_keys[n].value;
            typed_number.status = directed_keys[n].status;
            send_key(text, directed_keys[n].typed, typed_number);
        end

        // Random keys, opening with one whose length lies near or past the length limit.
        random_start = chars_counted;
        send_key(random_key(KEY_OVERLONG), 1'b0, '0);
        while (chars_counted - random_start < RANDOM_CHARS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                kind = KEY_WELL_FORMED;
            else if (pick < 75)
                kind = KEY_BIG;
            else if (pick < 86)
                kind = KEY_DIGITS_ONLY;
            else if (pick < 99)
                kind = KEY_NOISE;
            else
                kind = KEY_OVERLONG;
            if ($urandom_range(0, 3) == 0)
                chars_steady = !chars_steady;
            send_key(random_key(kind), 1'b0, '0);
        end
        key_chars.valid <= 1'b0;

        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d keys with %0d counted characters; checked %0d result beats.",
                 keys_sent, chars_counted, numbers_checked);
        $display("Results by status: ok %0d, no spaces %0d, saturated %0d; %0d mismatches.",
                 status_seen[STATUS_OK], status_seen[STATUS_NO_SPACES],
                 status_seen[STATUS_OVERFLOW], mismatches);
        if (mismatches == 0) begin
            $display("PASS websocket_key_number_decode_unit");
        end else begin
            $display("FAIL websocket_key_number_decode_unit");
        end
        $finish;
    end

endmodule
